### hdl/hbc_pkg.sv
// hbc_pkg: shared types and constants of the histogram background classifier
// no dependencies
`timescale 1ns / 1ps

package hbc_pkg;

  localparam int BIN_COUNT           = 256;
  localparam int BIN_W               = 8;
  localparam int MAX_PIXELS_LOG2_DEF = 24;
  localparam int OUT_SUM_W           = 25;
  localparam int EDGE_W              = 9;
  localparam int QUEUE_DEPTH         = 4;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             last;
  } bin_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_PEAK,
    ST_RWALK,
    ST_LWALK,
    ST_CALC,
    ST_SUMR,
    ST_SUML,
    ST_DONE
  } back_state_t;

endpackage

### hdl/hbc_ifs.sv
// hbc_ifs: pixel and result channel interfaces
// depends on nothing
`timescale 1ns / 1ps

interface hbc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;
  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface hbc_res_if;
  logic              valid;
  logic              ready;
  logic              dark_background;
  logic [7:0]        peak_bin;
  logic [8:0]        right_edge;
  logic signed [8:0] left_edge;
  logic [24:0]       upper_count;
  logic [24:0]       lower_count;
  modport source (output valid, dark_background, peak_bin, right_edge, left_edge,
                  upper_count, lower_count, input ready);
  modport sink (input valid, dark_background, peak_bin, right_edge, left_edge,
                upper_count, lower_count, output ready);
endinterface

### hdl/hbc_front.sv
// hbc_front: brightness bin of each pixel word and the queue toward the back end
// depends on hbc_pkg and hbc_pix_if
`timescale 1ns / 1ps

module hbc_front (
  input  logic             clk,
  input  logic             rst_n,
  hbc_pix_if.sink          in_ch,
  output logic             q_valid,
  output hbc_pkg::bin_word_t q_word,
  input  logic             q_ready
);
  import hbc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [9:0]       sum3;
  logic [19:0]      prod;
  bin_word_t        push_word;
  bin_word_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             push, pop;

  // divide by three through the reciprocal 683/2048, exact for sums up to 765
  assign sum3 = 10'(in_ch.red) + 10'(in_ch.green) + 10'(in_ch.blue);
  assign prod = 20'(sum3) * 20'd683;
  assign push_word.bin  = prod[18:11];
  assign push_word.last = in_ch.last_pixel;

  assign in_ch.ready = (cnt_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != '0);
  assign pop     = q_valid && q_ready;
  assign q_word  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop) rptr_r <= rptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

### hdl/hbc_back.sv
// hbc_back: histogram memory, update sequencer and decision scans
// depends on hbc_pkg and hbc_res_if
`timescale 1ns / 1ps

module hbc_back #(
  parameter int MAX_PIXELS_LOG2 = hbc_pkg::MAX_PIXELS_LOG2_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  hbc_pkg::bin_word_t q_word,
  output logic               q_ready,
  hbc_res_if.source          out_ch
);
  import hbc_pkg::*;

  localparam int CW = MAX_PIXELS_LOG2 + 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(1) << MAX_PIXELS_LOG2;

  back_state_t state_r, state_nxt;

  logic [CW-1:0]   hist_mem [BIN_COUNT];
  logic [CW-1:0]   rdata_r;
  logic [BIN_W-1:0] raddr, waddr;
  logic [CW-1:0]   wdata;
  logic            we;

  logic [8:0]        idx_r, idx_nxt;
  logic              ph_r, ph_nxt;
  logic [CW-1:0]     top_r, top_nxt;
  logic [7:0]        peak_r, peak_nxt;
  logic [8:0]        ri_r, ri_nxt;
  logic signed [8:0] le_r, le_nxt;
  logic [7:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0]     sr_r, sr_nxt, sl_r, sl_nxt;
  logic [7:0]        bin_r, bin_nxt;
  logic              last_r, last_nxt;

  logic              ov_r;
  logic              o_dark_r;
  logic [7:0]        o_peak_r;
  logic [8:0]        o_ri_r;
  logic signed [8:0] o_le_r;
  logic [CW-1:0]     o_sr_r, o_sl_r;

  logic [CW-1:0]  half, inc_val;
  logic           ge_half;
  logic [CW:0]    sr_sum, sl_sum;
  logic signed [10:0] lo_s, hi_s;
  logic           load_out;

  assign half    = top_r >> 1;
  assign ge_half = (rdata_r >= half);
  assign inc_val = (rdata_r < CNT_MAX) ? rdata_r + 1'b1 : rdata_r;
  assign sr_sum  = {1'b0, sr_r} + {1'b0, rdata_r};
  assign sl_sum  = {1'b0, sl_r} + {1'b0, rdata_r};
  assign lo_s    = $signed({le_r[8], le_r, 1'b0}) - $signed({3'b000, peak_r});
  assign hi_s    = $signed({1'b0, ri_r, 1'b0}) - $signed({3'b000, peak_r});
  assign load_out = (state_r == ST_DONE) && (!ov_r || out_ch.ready);

  // histogram memory
  assign raddr = (state_r == ST_IDLE) ? q_word.bin : idx_r[7:0];
  always_ff @(posedge clk) begin
    rdata_r <= hist_mem[raddr];
    if (we) hist_mem[waddr] <= wdata;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (idx_r[7:0] == 8'd255) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_valid) state_nxt = ST_INC;
      ST_INC:   state_nxt = last_r ? ST_PEAK : ST_IDLE;
      ST_PEAK:  if (ph_r && idx_r[7:0] == 8'd255) state_nxt = ST_RWALK;
      ST_RWALK: if (ph_r && (!ge_half || idx_r[7:0] == 8'd255)) state_nxt = ST_LWALK;
      ST_LWALK: if (ph_r && (!ge_half || idx_r[7:0] == 8'd0)) state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_SUMR;
      ST_SUMR:  if (ph_r && idx_r[7:0] == 8'd255) state_nxt = ST_SUML;
      ST_SUML:  if (ph_r && idx_r[7:0] == 8'd0) state_nxt = ST_DONE;
      ST_DONE:  if (load_out) state_nxt = ST_CLEAR;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    idx_nxt  = idx_r;
    ph_nxt   = ~ph_r;
    top_nxt  = top_r;
    peak_nxt = peak_r;
    ri_nxt   = ri_r;
    le_nxt   = le_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    sr_nxt   = sr_r;
    sl_nxt   = sl_r;
    bin_nxt  = bin_r;
    last_nxt = last_r;
    q_ready  = 1'b0;
    we       = 1'b0;
    waddr    = idx_r[7:0];
    wdata    = '0;
    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        idx_nxt = idx_r + 1'b1;
        ph_nxt  = 1'b0;
      end
      ST_IDLE: begin
        q_ready  = 1'b1;
        bin_nxt  = q_word.bin;
        last_nxt = q_word.last;
        ph_nxt   = 1'b0;
      end
      ST_INC: begin
        we      = 1'b1;
        waddr   = bin_r;
        wdata   = inc_val;
        idx_nxt = '0;
        ph_nxt  = 1'b0;
      end
      ST_PEAK: begin
        if (ph_r) begin
          if (idx_r == '0 || rdata_r > top_r) begin
            top_nxt  = rdata_r;
            peak_nxt = idx_r[7:0];
          end
          idx_nxt = idx_r + 1'b1;
          if (idx_r[7:0] == 8'd255) idx_nxt = {1'b0, peak_nxt};
        end
      end
      ST_RWALK: begin
        if (ph_r) begin
          if (!ge_half) begin
            ri_nxt  = idx_r;
            idx_nxt = {1'b0, peak_r};
          end else if (idx_r[7:0] == 8'd255) begin
            ri_nxt  = 9'd256;
            idx_nxt = {1'b0, peak_r};
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_LWALK: begin
        if (ph_r) begin
          if (!ge_half) begin
            le_nxt = $signed(idx_r);
          end else if (idx_r[7:0] == 8'd0) begin
            le_nxt = -9'sd1;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      ST_CALC: begin
        lo_nxt  = lo_s[10] ? 8'd0 : lo_s[7:0];
        hi_nxt  = (hi_s[10:8] != 3'b000) ? 8'd255 : hi_s[7:0];
        idx_nxt = {1'b0, lo_nxt};
        sr_nxt  = '0;
        sl_nxt  = '0;
        ph_nxt  = 1'b0;
      end
      ST_SUMR: begin
        if (ph_r) begin
          sr_nxt  = (sr_sum > {1'b0, CNT_MAX}) ? CNT_MAX : sr_sum[CW-1:0];
          idx_nxt = (idx_r[7:0] == 8'd255) ? {1'b0, hi_r} : idx_r + 1'b1;
        end
      end
      ST_SUML: begin
        if (ph_r) begin
          sl_nxt  = (sl_sum > {1'b0, CNT_MAX}) ? CNT_MAX : sl_sum[CW-1:0];
          idx_nxt = idx_r - 1'b1;
        end
      end
      ST_DONE: begin
        idx_nxt = '0;
        ph_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r   <= '0;
      ph_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ph_r    <= ph_nxt;
      if (load_out) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    peak_r <= peak_nxt;
    ri_r   <= ri_nxt;
    le_r   <= le_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    sr_r   <= sr_nxt;
    sl_r   <= sl_nxt;
    bin_r  <= bin_nxt;
    last_r <= last_nxt;
    if (load_out) begin
      o_dark_r <= (sr_r > sl_r);
      o_peak_r <= peak_r;
      o_ri_r   <= ri_r;
      o_le_r   <= le_r;
      o_sr_r   <= sr_r;
      o_sl_r   <= sl_r;
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.dark_background = o_dark_r;
  assign out_ch.peak_bin        = o_peak_r;
  assign out_ch.right_edge      = o_ri_r;
  assign out_ch.left_edge       = o_le_r;
  assign out_ch.upper_count     = OUT_SUM_W'(o_sr_r);
  assign out_ch.lower_count     = OUT_SUM_W'(o_sl_r);

endmodule

### hdl/histogram_background_classifier.sv
// Pixel words enter a four-word queue at up to one per cycle when not full.
// Each histogram update reads the bin count through the read port of the bin
// memory and writes it back through its write port; the next pixel is taken
// only once that write is done. The last pixel starts the decision: a peak
// scan, the two half-peak walks and the two sums, each reading a bin, then
// using its count, followed by a clearing pass of the memory. A clearing
// pass also runs after reset; the queue fills and then holds off input.
// Results sit in an output register, so the next image can start meanwhile.
// depends on hbc_pkg, hbc_ifs, hbc_front and hbc_back
`timescale 1ns / 1ps

module histogram_background_classifier #(
  parameter int MAX_PIXELS_LOG2 = hbc_pkg::MAX_PIXELS_LOG2_DEF
) (
  input logic       clk,
  input logic       rst_n,
  hbc_pix_if.sink   in_ch,
  hbc_res_if.source out_ch
);
  import hbc_pkg::*;

  logic      q_valid, q_ready;
  bin_word_t q_word;

  hbc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_ready (q_ready)
  );

  hbc_back #(
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  a_right_of_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.right_edge > {1'b0, out_ch.peak_bin}))
    else $error("right edge not right of peak");

  a_left_of_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($signed(out_ch.left_edge) < $signed({1'b0, out_ch.peak_bin})))
    else $error("left edge not left of peak");

  a_decision: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && MAX_PIXELS_LOG2 < 25) |->
      (out_ch.dark_background == (out_ch.upper_count > out_ch.lower_count)))
    else $error("decision does not follow sums");
`endif

endmodule
